/* rtl/clock_unit_detector_assert.svh */
// ----------------------------------------------------------------------------
// clock unit detector assertion macros
// Shared concurrent assertion forms used by the RTL checks.
// ----------------------------------------------------------------------------
`ifndef CLOCK_UNIT_DETECTOR_ASSERT_SVH
`define CLOCK_UNIT_DETECTOR_ASSERT_SVH

// same-cycle implication, off during reset
`define CUD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock unit detector check failed");

// next-cycle implication, off during reset
`define CUD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock unit detector check failed");

`endif

/* rtl/cud_pkg.sv */
// ----------------------------------------------------------------------------
// cud_pkg
// Types and constants shared by the clock unit detector modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cud_pkg;

    // time format, unsigned Q32.16
    localparam int TIME_BITS = 48;
    localparam int OUT_BITS  = TIME_BITS + 1;

    // configuration
    localparam int VOTE_BITS      = 4;
    localparam int MIN_DELTA_BITS = 16;
    localparam int CFG_ADDR_BITS  = 2;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_VOTES_NEEDED   = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_WALL_DELTA = 2'd1;

    localparam logic [VOTE_BITS-1:0]      VOTES_RESET     = 4'd4;
    localparam logic [MIN_DELTA_BITS-1:0] MIN_DELTA_RESET = 16'd33;

    // divide by 1000 as (x >> 3) / 125 with a 46-bit reciprocal, shift 52
    localparam int DIV_IN_BITS    = TIME_BITS - 3;
    localparam int DIV_MAGIC_BITS = 46;
    localparam logic [DIV_MAGIC_BITS-1:0] DIV_MAGIC = 46'd36028797018964;
    localparam int DIV_SHIFT      = 52;
    localparam int DIV_PROD_BITS  = DIV_IN_BITS + DIV_MAGIC_BITS;
    localparam int QUO_BITS       = DIV_PROD_BITS - DIV_SHIFT;

    // settled unit of the host clock
    typedef enum logic [1:0] {
        UNIT_NONE = 2'd0,
        UNIT_SEC  = 2'd1,
        UNIT_MSEC = 2'd2
    } unit_t;

    // per-tick vote qualification from the front stage
    typedef struct packed {
        logic qualify;
        logic sec_win;
        logic ms_win;
    } vote_flags_t;

endpackage

`default_nettype wire

/* rtl/cud_if.sv */
// ----------------------------------------------------------------------------
// cud channel interfaces
// Valid/ready channels for ticks, results and configuration writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cud_tick_if;
    import cud_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] host_time;
    logic                 host_present;
    logic [TIME_BITS-1:0] wall_time;

    modport source (output valid, host_time, host_present, wall_time, input ready);
    modport sink (input valid, host_time, host_present, wall_time, output ready);
endinterface

interface cud_result_if;
    import cud_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] elapsed_time;
    logic [1:0]                 unit_state;

    modport source (output valid, elapsed_time, unit_state, input ready);
    modport sink (input valid, elapsed_time, unit_state, output ready);
endinterface

interface cud_cfg_if;
    import cud_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, addr, data, input ready);
    modport sink (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* rtl/clock_unit_detector.sv */
// ----------------------------------------------------------------------------
// clock_unit_detector
// Decides whether a host clock counts seconds or milliseconds and turns each
// tick into elapsed seconds since the first tick.
//
// Usage:
//   tick    one beat per frame: host_time, host_present, wall_time (Q32.16)
//   result  one beat per tick: elapsed_time (signed Q32.16), unit_state
//   cfg     register writes, addr 0 votes_needed, addr 1 min_wall_delta;
//           always ready, write only while no tick is in flight
//   Throughput: one tick per cycle while result.ready stays high; the pipeline
//   is input register, window test, vote, and two divide-by-1000 multiply
//   stages into the output register.
//   Reset: votes cleared, unit unsettled, history and wall origin forgotten,
//   registers back to 4 and 33; the first tick after reset sets the origin.
//   Stall: when result.ready is low the beat holds, stages behind it keep
//   filling and tick.ready drops once every stage is occupied.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "clock_unit_detector_assert.svh"

module clock_unit_detector (
    input  wire logic      clk,
    input  wire logic      rst_n,
    cud_tick_if.sink       tick,
    cud_result_if.source   result,
    cud_cfg_if.sink        cfg
);
    import cud_pkg::*;

    // configuration
    logic [VOTE_BITS-1:0]      votes_needed_reg;
    logic [MIN_DELTA_BITS-1:0] min_wall_delta_reg;

    // pipeline valids and moves
    logic v0_reg, v1_reg, v2_reg, v3_reg, vout_reg;
    logic move0, move1, move2, move3;

    // stage payloads
    logic [TIME_BITS-1:0]       s0_host_reg;
    logic                       s0_present_reg;
    logic [TIME_BITS-1:0]       s0_wall_reg;
    vote_flags_t                s1_flags_reg;
    logic [TIME_BITS-1:0]       s1_host_reg;
    logic                       s1_present_reg;
    logic signed [OUT_BITS-1:0] s1_wall_diff_reg;
    unit_t                      s2_unit_reg;
    logic [TIME_BITS-1:0]       s2_host_reg;
    logic                       s2_present_reg;
    logic signed [OUT_BITS-1:0] s2_wall_diff_reg;
    unit_t                      s3_unit_reg;
    logic [TIME_BITS-1:0]       s3_host_reg;
    logic                       s3_present_reg;
    logic signed [OUT_BITS-1:0] s3_wall_diff_reg;
    logic signed [OUT_BITS-1:0] out_elapsed_reg;
    unit_t                      out_unit_reg;

    vote_flags_t                flags;
    logic signed [OUT_BITS-1:0] wall_diff;
    unit_t                      settled;
    unit_t                      unit_next;
    logic [QUO_BITS-1:0]        quotient;
    logic signed [OUT_BITS-1:0] elapsed_next;

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            votes_needed_reg   <= VOTES_RESET;
            min_wall_delta_reg <= MIN_DELTA_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.addr)
                CFG_VOTES_NEEDED:   votes_needed_reg   <= cfg.data[VOTE_BITS-1:0];
                CFG_MIN_WALL_DELTA: min_wall_delta_reg <= cfg.data[MIN_DELTA_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // stage advance, each stage moves when the next one is free or moving
    assign move3      = v3_reg && (!vout_reg || result.ready);
    assign move2      = v2_reg && (!v3_reg || move3);
    assign move1      = v1_reg && (!v2_reg || move2);
    assign move0      = v0_reg && (!v1_reg || move1);
    assign tick.ready = !v0_reg || move0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= (tick.valid && tick.ready) || (v0_reg && !move0);
            v1_reg   <= move0 || (v1_reg && !move1);
            v2_reg   <= move1 || (v2_reg && !move2);
            v3_reg   <= move2 || (v3_reg && !move3);
            vout_reg <= move3 || (vout_reg && !result.ready);
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            s0_host_reg    <= tick.host_time;
            s0_present_reg <= tick.host_present;
            s0_wall_reg    <= tick.wall_time;
        end
    end

    // window tests and history
    cud_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (move0),
        .host_time      (s0_host_reg),
        .host_present   (s0_present_reg),
        .wall_time      (s0_wall_reg),
        .min_wall_delta (min_wall_delta_reg),
        .flags          (flags),
        .wall_diff      (wall_diff)
    );

    always_ff @(posedge clk)
    begin
        if (move0)
        begin
            s1_flags_reg     <= flags;
            s1_host_reg      <= s0_host_reg;
            s1_present_reg   <= s0_present_reg;
            s1_wall_diff_reg <= wall_diff;
        end
    end

    // voting
    cud_vote u_vote (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (move1),
        .flags        (s1_flags_reg),
        .votes_needed (votes_needed_reg),
        .settled      (settled),
        .unit_next    (unit_next)
    );

    // millisecond divide, aligned with stages two and three
    cud_div1000 u_div (
        .clk       (clk),
        .en_a      (move1),
        .en_b      (move2),
        .host_time (s1_host_reg),
        .quotient  (quotient)
    );

    always_ff @(posedge clk)
    begin
        if (move1)
        begin
            s2_unit_reg      <= unit_next;
            s2_host_reg      <= s1_host_reg;
            s2_present_reg   <= s1_present_reg;
            s2_wall_diff_reg <= s1_wall_diff_reg;
        end
        if (move2)
        begin
            s3_unit_reg      <= s2_unit_reg;
            s3_host_reg      <= s2_host_reg;
            s3_present_reg   <= s2_present_reg;
            s3_wall_diff_reg <= s2_wall_diff_reg;
        end
    end

    // time source select; the epoch is the first tick's value, always zero
    always_comb
    begin
        priority if (s3_present_reg && (s3_unit_reg == UNIT_SEC))
        begin
            elapsed_next = $signed({1'b0, s3_host_reg});
        end
        else if (s3_present_reg && (s3_unit_reg == UNIT_MSEC))
        begin
            elapsed_next = $signed({{(OUT_BITS-QUO_BITS){1'b0}}, quotient});
        end
        else
        begin
            elapsed_next = s3_wall_diff_reg;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (move3)
        begin
            out_elapsed_reg <= elapsed_next;
            out_unit_reg    <= s3_unit_reg;
        end
    end

    assign result.valid        = vout_reg;
    assign result.elapsed_time = out_elapsed_reg;
    assign result.unit_state   = out_unit_reg;

    // checks
    `CUD_ASSERT_NEXT(a_settle_sticky, clk, rst_n, settled != UNIT_NONE, settled == $past(settled))
    `CUD_ASSERT_NEXT(a_settle_on_vote, clk, rst_n, !move1, $stable(settled))
    `CUD_ASSERT_NEXT(a_vote_stage_holds, clk, rst_n, v1_reg && !move1, v1_reg && $stable(s1_host_reg))

endmodule

`default_nettype wire

/* rtl/cud_front.sv */
// ----------------------------------------------------------------------------
// cud_front
// Tracks previous host and wall readings and the wall origin, and forms the
// delta window tests and the wall time since the first tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cud_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                en,
    input  wire logic [cud_pkg::TIME_BITS-1:0]       host_time,
    input  wire logic                                host_present,
    input  wire logic [cud_pkg::TIME_BITS-1:0]       wall_time,
    input  wire logic [cud_pkg::MIN_DELTA_BITS-1:0]  min_wall_delta,
    output cud_pkg::vote_flags_t                     flags,
    output logic signed [cud_pkg::OUT_BITS-1:0]      wall_diff
);
    import cud_pkg::*;

    localparam int X10_BITS    = TIME_BITS + 4;
    localparam int X100_BITS   = TIME_BITS + 7;
    localparam int X10000_BITS = TIME_BITS + 14;

    logic [TIME_BITS-1:0]   last_host_reg;
    logic                   last_host_valid_reg;
    logic [TIME_BITS-1:0]   last_wall_reg;
    logic [TIME_BITS-1:0]   origin_reg;
    logic                   seen_reg;

    logic [TIME_BITS-1:0]   hd;
    logic [TIME_BITS-1:0]   wd;
    logic [X10_BITS-1:0]    hd_x10;
    logic [X10_BITS-1:0]    wd_x10;
    logic [X100_BITS-1:0]   wd_x100;
    logic [X10000_BITS-1:0] wd_x10000;
    logic [TIME_BITS-1:0]   origin;
    logic                   deltas_ok;

    // deltas against the previous tick
    assign hd = host_time - last_host_reg;
    assign wd = wall_time - last_wall_reg;

    // constant multiples for the ratio windows
    assign hd_x10    = ({4'b0, hd} << 3) + ({4'b0, hd} << 1);
    assign wd_x10    = ({4'b0, wd} << 3) + ({4'b0, wd} << 1);
    assign wd_x100   = {7'b0, wd} * 7'd100;
    assign wd_x10000 = {14'b0, wd} * 14'd10000;

    // tick may vote: present, history known, host forward, wall forward enough
    assign deltas_ok = (host_time > last_host_reg) && (wall_time >= last_wall_reg) &&
                       (wd >= {{(TIME_BITS-MIN_DELTA_BITS){1'b0}}, min_wall_delta});

    always_comb
    begin
        flags.qualify = host_present && last_host_valid_reg && seen_reg && deltas_ok;
        flags.sec_win = (hd_x10 > {4'b0, wd}) && ({4'b0, hd} < wd_x10);
        flags.ms_win  = ({7'b0, hd} > wd_x100) && ({14'b0, hd} < wd_x10000);
    end

    // wall time since the first tick, origin taken from this tick if first
    assign origin    = seen_reg ? origin_reg : wall_time;
    assign wall_diff = $signed({1'b0, wall_time}) - $signed({1'b0, origin});

    // history valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_host_valid_reg <= 1'b0;
            seen_reg            <= 1'b0;
        end
        else if (en)
        begin
            seen_reg <= 1'b1;
            if (host_present)
            begin
                last_host_valid_reg <= 1'b1;
            end
        end
    end

    // history values
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            last_wall_reg <= wall_time;
            if (host_present)
            begin
                last_host_reg <= host_time;
            end
            if (!seen_reg)
            begin
                origin_reg <= wall_time;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/cud_vote.sv */
// ----------------------------------------------------------------------------
// cud_vote
// Counts seconds and milliseconds votes and settles the host clock unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cud_vote (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire cud_pkg::vote_flags_t           flags,
    input  wire logic [cud_pkg::VOTE_BITS-1:0]  votes_needed,
    output cud_pkg::unit_t                      settled,
    output cud_pkg::unit_t                      unit_next
);
    import cud_pkg::*;

    localparam logic [VOTE_BITS-1:0] VOTE_MAX = {VOTE_BITS{1'b1}};

    logic [VOTE_BITS-1:0] sec_votes_reg;
    logic [VOTE_BITS-1:0] sec_votes_next;
    logic [VOTE_BITS-1:0] ms_votes_reg;
    logic [VOTE_BITS-1:0] ms_votes_next;
    unit_t                settled_reg;
    unit_t                settled_next;

    // saturating increment
    function automatic logic [VOTE_BITS-1:0] vote_bump(input logic [VOTE_BITS-1:0] v);
        return (v == VOTE_MAX) ? v : v + {{(VOTE_BITS-1){1'b0}}, 1'b1};
    endfunction

    // vote and settle for the current tick
    always_comb
    begin
        sec_votes_next = sec_votes_reg;
        ms_votes_next  = ms_votes_reg;
        settled_next   = settled_reg;
        if ((settled_reg == UNIT_NONE) && flags.qualify)
        begin
            if (flags.sec_win)
            begin
                sec_votes_next = vote_bump(sec_votes_reg);
            end
            else if (flags.ms_win)
            begin
                ms_votes_next = vote_bump(ms_votes_reg);
            end
            if ((sec_votes_next >= votes_needed) || (ms_votes_next >= votes_needed))
            begin
                settled_next = (ms_votes_next > sec_votes_next) ? UNIT_MSEC : UNIT_SEC;
            end
        end
    end

    // vote state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_votes_reg <= '0;
            ms_votes_reg  <= '0;
            settled_reg   <= UNIT_NONE;
        end
        else if (en)
        begin
            sec_votes_reg <= sec_votes_next;
            ms_votes_reg  <= ms_votes_next;
            settled_reg   <= settled_next;
        end
    end

    assign settled   = settled_reg;
    assign unit_next = settled_next;

endmodule

`default_nettype wire

/* rtl/cud_div1000.sv */
// ----------------------------------------------------------------------------
// cud_div1000
// Two-stage divide of a host reading by 1000 through a reciprocal multiply
// split into four partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cud_div1000 (
    input  wire logic                            clk,
    input  wire logic                            en_a,
    input  wire logic                            en_b,
    input  wire logic [cud_pkg::TIME_BITS-1:0]   host_time,
    output logic [cud_pkg::QUO_BITS-1:0]         quotient
);
    import cud_pkg::*;

    localparam int XL_BITS  = 23;
    localparam int XH_BITS  = DIV_IN_BITS - XL_BITS;
    localparam int ML_BITS  = 23;
    localparam int MH_BITS  = DIV_MAGIC_BITS - ML_BITS;
    localparam int LL_BITS  = XL_BITS + ML_BITS;
    localparam int LH_BITS  = XL_BITS + MH_BITS;
    localparam int HL_BITS  = XH_BITS + ML_BITS;
    localparam int HH_BITS  = XH_BITS + MH_BITS;
    localparam int MID_BITS = LH_BITS + 1;

    logic [DIV_IN_BITS-1:0]   x;
    logic [XL_BITS-1:0]       xl;
    logic [XH_BITS-1:0]       xh;
    logic [LL_BITS-1:0]       ll_reg;
    logic [LH_BITS-1:0]       lh_reg;
    logic [HL_BITS-1:0]       hl_reg;
    logic [HH_BITS-1:0]       hh_a_reg;
    logic [LL_BITS-1:0]       ll_b_reg;
    logic [MID_BITS-1:0]      mid_reg;
    logic [HH_BITS-1:0]       hh_b_reg;
    logic [DIV_PROD_BITS-1:0] total;

    // divide by 8 first, the reciprocal covers the divide by 125
    assign x  = host_time[TIME_BITS-1:3];
    assign xl = x[XL_BITS-1:0];
    assign xh = x[DIV_IN_BITS-1:XL_BITS];

    // stage a: partial products
    always_ff @(posedge clk)
    begin
        if (en_a)
        begin
            ll_reg   <= {{(LL_BITS-XL_BITS){1'b0}}, xl} *
                        {{(LL_BITS-ML_BITS){1'b0}}, DIV_MAGIC[ML_BITS-1:0]};
            lh_reg   <= {{MH_BITS{1'b0}}, xl} *
                        {{XL_BITS{1'b0}}, DIV_MAGIC[DIV_MAGIC_BITS-1:ML_BITS]};
            hl_reg   <= {{ML_BITS{1'b0}}, xh} * {{XH_BITS{1'b0}}, DIV_MAGIC[ML_BITS-1:0]};
            hh_a_reg <= {{MH_BITS{1'b0}}, xh} *
                        {{XH_BITS{1'b0}}, DIV_MAGIC[DIV_MAGIC_BITS-1:ML_BITS]};
        end
    end

    // stage b: fold the cross terms
    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            mid_reg  <= {1'b0, lh_reg} + {{(MID_BITS-HL_BITS){1'b0}}, hl_reg};
            ll_b_reg <= ll_reg;
            hh_b_reg <= hh_a_reg;
        end
    end

    // final sum and shift
    assign total = ({{(DIV_PROD_BITS-HH_BITS){1'b0}}, hh_b_reg} << (XL_BITS + ML_BITS)) +
                   ({{(DIV_PROD_BITS-MID_BITS){1'b0}}, mid_reg} << XL_BITS) +
                   {{(DIV_PROD_BITS-LL_BITS){1'b0}}, ll_b_reg};

    assign quotient = total[DIV_PROD_BITS-1:DIV_SHIFT];

endmodule

`default_nettype wire

/* tb/sv/clock_unit_detector_checker.sv */
// ----------------------------------------------------------------------------
// clock unit detector checker
// Watches the tick, result and register channels, keeps its own copy of the
// voting state and registers, works out each elapsed reading and compares it
// field by field with the result beats in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clock_unit_detector_checker
    import cud_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    cud_tick_if   tick,
    cud_result_if result,
    cud_cfg_if    cfg,
    output int    mismatch_count,
    output int    pending_count
);

    localparam int MAX_REPORTS = 10;
    localparam logic signed [63:0] SAT_LIMIT = (64'sd1 <<< TIME_BITS) - 64'sd1;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] elapsed;
        unit_t                      unit;
    } reading_t;

    reading_t due_readings[$];
    int       mismatch_total = 0;
    int       due_total      = 0;

    // register copies
    logic [VOTE_BITS-1:0]      votes_needed   = VOTES_RESET;
    logic [MIN_DELTA_BITS-1:0] min_wall_delta = MIN_DELTA_RESET;

    // detector state
    logic [VOTE_BITS-1:0] sec_votes;
    logic [VOTE_BITS-1:0] ms_votes;
    unit_t                settled;
    logic [TIME_BITS-1:0] prev_host;
    logic [TIME_BITS-1:0] prev_wall;
    logic [TIME_BITS-1:0] origin_wall;
    logic                 prev_host_seen;
    logic                 prev_wall_seen;
    logic                 origin_seen;
    logic                 epoch_seen;
    logic signed [63:0]   epoch;

    assign mismatch_count = mismatch_total;
    assign pending_count  = due_total;

    // vote counters stick at their top value
    function automatic logic [VOTE_BITS-1:0] bump_vote(input logic [VOTE_BITS-1:0] count);
        return (count == {VOTE_BITS{1'b1}}) ? count : count + 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        if (mismatch_total < MAX_REPORTS)
            $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
        mismatch_total++;
    endtask

    // one tick in, one reading out
    task automatic compute_reading(input logic [TIME_BITS-1:0] host, input logic present,
                                   input logic [TIME_BITS-1:0] wall);
        logic [63:0]        host_step;
        logic [63:0]        wall_step;
        logic signed [63:0] seconds;
        logic signed [63:0] span;
        reading_t           reading;

        if (!origin_seen)
        begin
            origin_wall = wall;
            origin_seen = 1'b1;
        end

        // voting while the unit is still open
        if (settled == UNIT_NONE && present && prev_host_seen && prev_wall_seen)
        begin
            host_step = 64'(host) - 64'(prev_host);
            wall_step = 64'(wall) - 64'(prev_wall);
            if (host > prev_host && wall >= prev_wall && wall_step >= 64'(min_wall_delta))
            begin
                if (host_step * 64'd10 > wall_step && host_step < wall_step * 64'd10)
                    sec_votes = bump_vote(sec_votes);
                else if (host_step > wall_step * 64'd100 &&
                         host_step < wall_step * 64'd10000)
                    ms_votes = bump_vote(ms_votes);
                if (sec_votes >= votes_needed || ms_votes >= votes_needed)
                    settled = (ms_votes > sec_votes) ? UNIT_MSEC : UNIT_SEC;
            end
        end

        // history for the next tick
        if (present)
        begin
            prev_host      = host;
            prev_host_seen = 1'b1;
        end
        prev_wall      = wall;
        prev_wall_seen = 1'b1;

        // host time once settled, wall time since origin otherwise
        if (present && settled == UNIT_SEC)
            seconds = 64'(host);
        else if (present && settled == UNIT_MSEC)
            seconds = 64'(host) / 64'd1000;
        else
            seconds = 64'(wall) - 64'(origin_wall);

        if (!epoch_seen)
        begin
            epoch      = seconds;
            epoch_seen = 1'b1;
        end

        // offset from epoch, clamped to the signed range
        span = seconds - epoch;
        if (span > SAT_LIMIT)
            span = SAT_LIMIT;
        else if (span < -SAT_LIMIT)
            span = -SAT_LIMIT;

        reading.elapsed = span[OUT_BITS-1:0];
        reading.unit    = settled;
        due_readings.push_back(reading);
    endtask

    task automatic check_reading();
        reading_t want;

        if (due_readings.size() == 0)
            flag_mismatch("result beat with no tick waiting, elapsed_time", 64'd0,
                          64'(result.elapsed_time));
        else
        begin
            want = due_readings.pop_front();
            if (result.elapsed_time !== want.elapsed)
                flag_mismatch("elapsed_time", 64'(want.elapsed), 64'(result.elapsed_time));
            if (result.unit_state !== want.unit)
                flag_mismatch("unit_state", 64'(want.unit), 64'(result.unit_state));
        end
    endtask

    // sample every channel at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            votes_needed   = VOTES_RESET;
            min_wall_delta = MIN_DELTA_RESET;
            sec_votes      = '0;
            ms_votes       = '0;
            settled        = UNIT_NONE;
            prev_host      = '0;
            prev_wall      = '0;
            origin_wall    = '0;
            prev_host_seen = 1'b0;
            prev_wall_seen = 1'b0;
            origin_seen    = 1'b0;
            epoch_seen     = 1'b0;
            epoch          = '0;
            due_readings.delete();
            due_total <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    CFG_VOTES_NEEDED:   votes_needed = cfg.data[VOTE_BITS-1:0];
                    CFG_MIN_WALL_DELTA: min_wall_delta = cfg.data[MIN_DELTA_BITS-1:0];
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
                check_reading();
            if (tick.valid && tick.ready)
                compute_reading(tick.host_time, tick.host_present, tick.wall_time);
            due_total <= due_readings.size();
        end
    end

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// clock unit detector testbench
// Drives ticks and register writes into the detector: a directed run over
// the voting windows, their edges and the odd cases, then three random
// phases under different register settings and idle patterns, one of them
// with a long result stall. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import cud_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int CFG_GAP         = 8;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLD_CYCLES     = 200;
    localparam int ITEMS_PER_PHASE = 150;

    localparam logic [TIME_BITS-1:0]     TIME_MAX     = '1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE_HI = 2'd3;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int mismatches;
    int outstanding;

    logic hold_results  = 1'b0;
    logic pressure_req  = 1'b0;

    // generator history for well-formed tick runs
    logic [TIME_BITS-1:0]      trail_host;
    logic [TIME_BITS-1:0]      trail_wall;
    logic [MIN_DELTA_BITS-1:0] cur_min_delta = MIN_DELTA_RESET;

    cud_tick_if   tick_ch ();
    cud_result_if result_ch ();
    cud_cfg_if    cfg_ch ();

    clock_unit_detector i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    clock_unit_detector_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick_ch),
        .result         (result_ch),
        .cfg            (cfg_ch),
        .mismatch_count (mismatches),
        .pending_count  (outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("clock_unit_detector verification failed");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge clk)
        result_ch.ready <= !hold_results && ($urandom_range(99) >= recv_idle_pct);

    // long result stall so the pipeline fills and the tick side backs up
    initial
    begin
        wait (pressure_req);
        @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results <= 1'b0;
    end

    // offer one tick beat, leaving valid high once it is taken
    task automatic send_tick(input logic [TIME_BITS-1:0] host, input logic present,
                             input logic [TIME_BITS-1:0] wall);
        if ($urandom_range(99) < send_idle_pct)
        begin
            tick_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        tick_ch.valid        <= 1'b1;
        tick_ch.host_time    <= host;
        tick_ch.host_present <= present;
        tick_ch.wall_time    <= wall;
        do
            @(negedge clk);
        while (!tick_ch.ready);
        @(posedge clk);
    endtask

    // stop offering and let every reading come back
    task automatic quiesce(input int settle_cycles);
        tick_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (settle_cycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= index;
        cfg_ch.data  <= value;
        do
            @(negedge clk);
        while (!cfg_ch.ready);
        @(posedge clk);
    endtask

    // both registers plus one write to an unused index
    task automatic configure(input logic [CFG_DATA_BITS-1:0] votes,
                             input logic [CFG_DATA_BITS-1:0] min_delta);
        quiesce(CFG_GAP);
        write_reg(CFG_VOTES_NEEDED, votes);
        write_reg(CFG_MIN_WALL_DELTA, min_delta);
        write_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                  CFG_DATA_BITS'($urandom));
        cfg_ch.valid  <= 1'b0;
        cur_min_delta = min_delta;
    endtask

    // mostly well-formed tick runs, with noise and broken ticks mixed in
    task automatic send_random_ticks(input int count, input int vote_pct);
        logic [TIME_BITS-1:0] host;
        logic [TIME_BITS-1:0] wall;
        logic [63:0]          wall_step;
        logic [63:0]          host_step;
        logic [63:0]          noise;
        logic                 present;
        int                   pick;

        for (int n = 0; n < count; n++)
        begin
            pick    = $urandom_range(99);
            present = ($urandom_range(9) != 0);
            host    = trail_host;
            wall    = trail_wall;
            if (pick < 75)
            begin
                // wall step around the minimum
                case ($urandom_range(3))
                    0: wall_step = 64'(cur_min_delta);
                    1: wall_step = 64'(cur_min_delta) + $urandom_range(64);
                    2: wall_step = 64'(cur_min_delta) + $urandom_range(70000);
                    default: wall_step = $urandom_range(cur_min_delta);
                endcase
                // host step inside a window, on its edge or between windows
                if ($urandom_range(99) < vote_pct)
                    host_step = $urandom_range(1) ? (wall_step * $urandom_range(99, 2)) / 10
                                                  : wall_step * $urandom_range(9999, 101);
                else
                begin
                    case ($urandom_range(7))
                        0: host_step = wall_step * 10;
                        1: host_step = wall_step / 10;
                        2: host_step = wall_step * 100;
                        3: host_step = wall_step * 10000;
                        4: host_step = wall_step * $urandom_range(99, 11);
                        5: host_step = wall_step * 100 + 1;
                        6: host_step = wall_step * 10 - 1;
                        default: host_step = $urandom_range(3);
                    endcase
                end
                host = trail_host + host_step[TIME_BITS-1:0];
                wall = trail_wall + wall_step[TIME_BITS-1:0];
            end
            else if (pick < 90)
            begin
                noise   = {$urandom, $urandom};
                host    = noise[TIME_BITS-1:0];
                noise   = {$urandom, $urandom};
                wall    = noise[TIME_BITS-1:0];
                present = 1'($urandom_range(1));
            end
            else
            begin
                // broken ticks: wall backwards, host stuck or backwards
                case ($urandom_range(2))
                    0: wall = trail_wall - $urandom_range(1000, 1);
                    1: wall = trail_wall + $urandom_range(70000);
                    default:
                    begin
                        host = trail_host - $urandom_range(1000, 1);
                        wall = trail_wall + $urandom_range(70000);
                    end
                endcase
            end
            send_tick(host, present, wall);
            if (present)
                trail_host = host;
            trail_wall = wall;
        end
    endtask

    initial
    begin
        tick_ch.valid        <= 1'b0;
        tick_ch.host_time    <= '0;
        tick_ch.host_present <= 1'b0;
        tick_ch.wall_time    <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.addr          <= CFG_VOTES_NEEDED;
        cfg_ch.data          <= '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed ticks under the reset register values
        send_idle_pct = 14;
        recv_idle_pct <= 58;
        send_tick(100, 1'b1, 100000);       // first tick sets origin and epoch
        send_tick(0, 1'b1, 101000);         // host going backwards, host at zero
        send_tick(5000, 1'b0, 102000);      // host absent
        send_tick(2000, 1'b1, 102032);      // wall step just under the minimum
        send_tick(2330, 1'b1, 102065);      // ratio exactly ten
        send_tick(2363, 1'b1, 102395);      // ratio exactly one tenth
        send_tick(2692, 1'b1, 102428);      // just under ten, seconds vote
        send_tick(2726, 1'b1, 102758);      // just over one tenth, seconds vote
        send_tick(6726, 1'b1, 102798);      // ratio exactly one hundred
        send_tick(406726, 1'b1, 102838);    // ratio exactly ten thousand
        send_tick(410727, 1'b1, 102878);    // just over one hundred, ms vote
        send_tick(810726, 1'b1, 102918);    // just under ten thousand, ms vote
        send_tick(810727, 1'b1, 102900);    // wall going backwards
        send_tick(810727, 1'b1, 103000);    // host unchanged
        send_tick(TIME_MAX, 1'b1, 50000);   // wall before origin, host at max
        send_tick(0, 1'b1, 0);              // wall at zero
        send_tick(1234567, 1'b0, TIME_MAX); // wall at max, host absent
        send_tick(TIME_MAX, 1'b1, TIME_MAX);

        // phase one: strict settings, few agreeing ticks
        configure(CFG_DATA_BITS'(($urandom_range(4095) << VOTE_BITS) | 15), 16'd65535);
        trail_host = $urandom;
        trail_wall = TIME_BITS'({$urandom_range(255), $urandom});
        send_random_ticks(ITEMS_PER_PHASE, 10);

        // phase two: loose settings, idling swapped
        configure(CFG_DATA_BITS'($urandom_range(14, 2)), 16'd1);
        send_idle_pct = 58;
        recv_idle_pct <= 14;
        send_random_ticks(ITEMS_PER_PHASE, 70);

        // phase three: zero vote threshold, no idling, one long result stall
        configure(CFG_DATA_BITS'(0), CFG_DATA_BITS'($urandom_range(65535, 1)));
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        pressure_req  <= 1'b1;
        send_random_ticks(ITEMS_PER_PHASE, 50);

        quiesce(DRAIN_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("clock_unit_detector verification clean");
        else
            $display("clock_unit_detector verification failed");
        $finish;
    end

endmodule
